// ----- design/elf_bid_pkg.sv -----
// Shared types and constants for the ELF build-id note extractor.
`default_nettype none

package elf_bid_pkg;

  // Number of descriptor bytes in an accepted build identifier
  localparam int unsigned ID_BYTES = 20;
  localparam int unsigned IDX_W    = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;

  // Widths of the configuration port and of the size counter
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CNT_W      = 33;

  // Note header layout: three little-endian 32-bit words
  localparam logic [CNT_W-1:0] HDR_NAMESZ_END = CNT_W'(4);
  localparam logic [CNT_W-1:0] HDR_DESCSZ_END = CNT_W'(8);
  localparam logic [CNT_W-1:0] HDR_TYPE_END   = CNT_W'(12);
  localparam logic [31:0]      NAME_BYTES     = 32'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_WORD = 1'b1;

  // Configuration reset values: type 3, name "GNU" then zero
  localparam logic [31:0] RST_NOTE_TYPE = 32'd3;
  localparam logic [31:0] RST_NAME_WORD = 32'h0055_4E47;

  // Parse phase within a note
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_DESC   = 2'd2
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    FAIL_OK        = 3'd0,
    FAIL_TRUNC     = 3'd1,
    FAIL_SIZE      = 3'd2,
    FAIL_DUP       = 3'd3,
    FAIL_NOT_FOUND = 3'd4
  } fail_e;

  // Field length rounded up to a multiple of four, one bit wider
  function automatic logic [CNT_W-1:0] pad4(input logic [31:0] len);
    logic [CNT_W-1:0] sum;
    sum  = {1'b0, len} + CNT_W'(3);
    pad4 = {sum[CNT_W-1:2], 2'b00};
  endfunction

endpackage

`default_nettype wire

// ----- design/elf_bid_if.sv -----
// Valid/ready channel interfaces for section bytes and extracted results.
`default_nettype none

interface elf_bid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface elf_bid_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] id_byte;
  logic       success;
  logic [2:0] fail_reason;
  logic       run_end;

  modport source (output valid, output id_byte, output success, output fail_reason,
                  output run_end, input ready);
  modport sink   (input valid, input id_byte, input success, input fail_reason,
                  input run_end, output ready);
endinterface

`default_nettype wire

// ----- design/elf_note_build_id_extractor_unit.sv -----
// Top level: ELF note section parser that extracts a unique build identifier.
//
// Takes an ELF note section one byte per transaction, the last byte flagged by
// final_byte. Each byte is parsed in the cycle it is taken, so section bytes
// flow at one per cycle unless a run is under way or a result is held. Nothing is
// emitted before the final byte; then either a single failure result (reason
// 1..4) or a run of ID_BYTES identifier bytes with success set and run_end on
// the last one. A failure result is loaded as the final byte is taken. After
// a successful final byte the input is held off while results load from the
// identifier store, one per cycle unless the output stalls. Configuration
// writes take effect at the next edge and are meant for idle periods only.
`default_nettype none

module elf_note_build_id_extractor_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [elf_bid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [elf_bid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  elf_bid_in_if.sink                            in_i,
  elf_bid_out_if.source                         out_o
);
  import elf_bid_pkg::*;

  // Configuration registers
  logic [31:0] want_type_q;
  logic [31:0] want_name_q;

  // Parse state
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] fc_q, fc_d, fc_inc;
  logic [31:0]      shift_q, shift_d;
  logic [31:0]      nlen_q, nlen_d;
  logic [31:0]      dlen_q, dlen_d;
  logic [31:0]      type_q, type_d;
  logic             nmatch_q, nmatch_d;
  logic             found_q, found_d;
  fail_e            err_q, err_d;
  fail_e            reason;

  // Identifier store, written during the matching descriptor
  logic [7:0]       id_store_q [ID_BYTES];
  logic             store_we;

  // Result side
  logic             run_busy_q, run_busy_d;
  logic [IDX_W-1:0] emit_idx_q, emit_idx_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_succ_q, out_succ_d;
  fail_e            out_reason_q, out_reason_d;
  logic             out_end_q, out_end_d;
  logic             out_load;

  logic             slot_free;
  logic             in_acc;
  logic [7:0]       in_byte;
  logic [7:0]       want_byte;
  logic             to_desc;
  logic             fin_note;
  logic             emit_last;

  assign in_byte   = in_i.data_byte;
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = !run_busy_q && slot_free;
  assign in_acc    = in_i.valid && in_i.ready;

  // Expected name byte for the current name position
  always_comb begin
    unique case (fc_q[1:0])
      2'd0:    want_byte = want_name_q[7:0];
      2'd1:    want_byte = want_name_q[15:8];
      2'd2:    want_byte = want_name_q[23:16];
      default: want_byte = want_name_q[31:24];
    endcase
  end

  // Per-byte parse step; frozen once an error has been latched
  always_comb begin
    phase_d  = phase_q;
    fc_d     = fc_q;
    shift_d  = shift_q;
    nlen_d   = nlen_q;
    dlen_d   = dlen_q;
    type_d   = type_q;
    nmatch_d = nmatch_q;
    found_d  = found_q;
    err_d    = err_q;
    store_we = 1'b0;
    to_desc  = 1'b0;
    fin_note = 1'b0;
    fc_inc   = fc_q + CNT_W'(1);
    if (err_q == FAIL_OK) begin
      unique case (phase_q)
        PH_HEADER: begin
          shift_d = {in_byte, shift_q[31:8]};
          fc_d    = fc_inc;
          if (fc_inc == HDR_NAMESZ_END) begin
            nlen_d = shift_d;
          end else if (fc_inc == HDR_DESCSZ_END) begin
            dlen_d = shift_d;
          end else if (fc_inc >= HDR_TYPE_END) begin
            type_d   = shift_d;
            nmatch_d = (nlen_q == NAME_BYTES);
            fc_d     = '0;
            if (nlen_q != '0) begin
              phase_d = PH_NAME;
            end else begin
              to_desc = 1'b1;
            end
          end
        end
        PH_NAME: begin
          if ((fc_q < CNT_W'(NAME_BYTES)) && nmatch_q && (in_byte != want_byte)) begin
            nmatch_d = 1'b0;
          end
          fc_d = fc_inc;
          if (fc_inc >= pad4(nlen_q)) begin
            to_desc = 1'b1;
          end
        end
        PH_DESC: begin
          if (nmatch_q && (type_q == want_type_q) && !found_q &&
              (dlen_q == 32'(ID_BYTES)) && (fc_q < CNT_W'(ID_BYTES))) begin
            store_we = 1'b1;
          end
          fc_d = fc_inc;
          if (fc_inc >= pad4(dlen_q)) begin
            fin_note = 1'b1;
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase

      // Name done: move to the descriptor, or close an empty one at once
      if (to_desc) begin
        fc_d = '0;
        if (dlen_d != '0) begin
          phase_d = PH_DESC;
        end else begin
          fin_note = 1'b1;
        end
      end

      // Note done: judge a build-id note
      if (fin_note) begin
        if (nmatch_d && (type_d == want_type_q)) begin
          if (dlen_d != 32'(ID_BYTES)) begin
            err_d = FAIL_SIZE;
          end else if (found_q) begin
            err_d = FAIL_DUP;
          end else begin
            found_d = 1'b1;
          end
        end
        phase_d = PH_HEADER;
        fc_d    = '0;
      end
    end
  end

  // Section verdict at the final byte
  always_comb begin
    priority if (err_d != FAIL_OK) begin
      reason = err_d;
    end else if ((phase_d != PH_HEADER) || (fc_d != '0)) begin
      reason = FAIL_TRUNC;
    end else if (!found_d) begin
      reason = FAIL_NOT_FOUND;
    end else begin
      reason = FAIL_OK;
    end
  end

  // Result register loading: failure result directly, success run from the store
  assign emit_last = (emit_idx_q == IDX_W'(ID_BYTES - 1));

  always_comb begin
    run_busy_d   = run_busy_q;
    emit_idx_d   = emit_idx_q;
    out_load     = 1'b0;
    out_byte_d   = out_byte_q;
    out_succ_d   = out_succ_q;
    out_reason_d = out_reason_q;
    out_end_d    = out_end_q;
    if (in_acc && in_i.final_byte) begin
      if (reason == FAIL_OK) begin
        run_busy_d = 1'b1;
        emit_idx_d = '0;
      end else begin
        out_load     = 1'b1;
        out_byte_d   = 8'd0;
        out_succ_d   = 1'b0;
        out_reason_d = reason;
        out_end_d    = 1'b1;
      end
    end else if (run_busy_q && slot_free) begin
      out_load     = 1'b1;
      out_byte_d   = id_store_q[emit_idx_q];
      out_succ_d   = 1'b1;
      out_reason_d = FAIL_OK;
      out_end_d    = emit_last;
      emit_idx_d   = emit_idx_q + IDX_W'(1);
      if (emit_last) begin
        run_busy_d = 1'b0;
      end
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and parse registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_type_q <= RST_NOTE_TYPE;
      want_name_q <= RST_NAME_WORD;
      phase_q     <= PH_HEADER;
      fc_q        <= '0;
      shift_q     <= '0;
      nlen_q      <= '0;
      dlen_q      <= '0;
      type_q      <= '0;
      nmatch_q    <= 1'b0;
      found_q     <= 1'b0;
      err_q       <= FAIL_OK;
      run_busy_q  <= 1'b0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_NOTE_TYPE: want_type_q <= cfg_data_i;
          REG_NAME_WORD: want_name_q <= cfg_data_i;
          default:       ;
        endcase
      end
      if (in_acc) begin
        if (in_i.final_byte) begin
          phase_q  <= PH_HEADER;
          fc_q     <= '0;
          shift_q  <= '0;
          nlen_q   <= '0;
          dlen_q   <= '0;
          type_q   <= '0;
          nmatch_q <= 1'b0;
          found_q  <= 1'b0;
          err_q    <= FAIL_OK;
        end else begin
          phase_q  <= phase_d;
          fc_q     <= fc_d;
          shift_q  <= shift_d;
          nlen_q   <= nlen_d;
          dlen_q   <= dlen_d;
          type_q   <= type_d;
          nmatch_q <= nmatch_d;
          found_q  <= found_d;
          err_q    <= err_d;
        end
      end
      run_busy_q  <= run_busy_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: identifier store and result fields
  always_ff @(posedge clk_i) begin
    if (in_acc && store_we) begin
      id_store_q[fc_q[IDX_W-1:0]] <= in_byte;
    end
    out_byte_q   <= out_byte_d;
    out_succ_q   <= out_succ_d;
    out_reason_q <= out_reason_d;
    out_end_q    <= out_end_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.id_byte     = out_byte_q;
  assign out_o.success     = out_succ_q;
  assign out_o.fail_reason = out_reason_q;
  assign out_o.run_end     = out_end_q;

endmodule

`default_nettype wire

// ----- test/elf_note_build_id_extractor_unit_test.sv -----
// Testbench for the ELF build-id note extractor: section streams, predicted results, checks.
`default_nettype none

module elf_note_build_id_extractor_unit_test;
  import elf_bid_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // One expected result transaction
  typedef struct packed {
    logic [7:0] id_byte;
    logic       success;
    fail_e      fail_reason;
    logic       run_end;
  } id_result_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_EVERY_THIRD,
    RX_COIN,
    RX_LONG_STALLS
  } rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  elf_bid_in_if  byte_ch ();
  elf_bid_out_if id_ch ();

  elf_note_build_id_extractor_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (byte_ch),
    .out_o      (id_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Settings as last written to the block
  logic [31:0] want_type = RST_NOTE_TYPE;
  logic [31:0] want_name = RST_NAME_WORD;

  // Parser state mirror
  phase_e           sec_phase   = PH_HEADER;
  logic [CNT_W-1:0] byte_pos    = '0;
  logic [31:0]      hdr_word    = '0;
  logic [31:0]      name_len    = '0;
  logic [31:0]      desc_size   = '0;
  logic [31:0]      hdr_type    = '0;
  logic             name_hit    = 1'b0;
  logic             id_seen     = 1'b0;
  fail_e            first_fault = FAIL_OK;
  logic [7:0]       id_copy [ID_BYTES];

  id_result_t  pending_results [$];
  logic [7:0]  section_bytes [$];
  int unsigned sent_bytes   = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int          burst_left   = 0;
  int unsigned rx_cycle     = 0;
  int unsigned rx_hold      = 0;

  initial begin
    for (int k = 0; k < ID_BYTES; k++) id_copy[k] = 8'h00;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [CNT_W-1:0] padded_size(input logic [31:0] n);
    padded_size = ({1'b0, n} + CNT_W'(3)) & ~CNT_W'(3);
  endfunction

  function automatic logic is_build_id_note();
    is_build_id_note = name_hit && (hdr_type == want_type);
  endfunction

  function automatic void close_note();
    if (is_build_id_note()) begin
      if (desc_size != 32'(ID_BYTES)) first_fault = FAIL_SIZE;
      else if (id_seen) first_fault = FAIL_DUP;
      else id_seen = 1'b1;
    end
    sec_phase = PH_HEADER;
    byte_pos  = '0;
  endfunction

  function automatic void open_descriptor();
    byte_pos = '0;
    if (padded_size(desc_size) == '0) close_note();
    else sec_phase = PH_DESC;
  endfunction

  function automatic void open_name();
    byte_pos = '0;
    if (padded_size(name_len) == '0) open_descriptor();
    else sec_phase = PH_NAME;
  endfunction

  function automatic void clear_section();
    sec_phase   = PH_HEADER;
    byte_pos    = '0;
    hdr_word    = '0;
    name_len    = '0;
    desc_size   = '0;
    hdr_type    = '0;
    name_hit    = 1'b0;
    id_seen     = 1'b0;
    first_fault = FAIL_OK;
  endfunction

  function automatic void parse_note_byte(input logic [7:0] b);
    case (sec_phase)
      PH_HEADER: begin
        hdr_word = {b, hdr_word[31:8]};
        byte_pos++;
        if (byte_pos == HDR_NAMESZ_END) begin
          name_len = hdr_word;
        end else if (byte_pos == HDR_DESCSZ_END) begin
          desc_size = hdr_word;
        end else if (byte_pos >= HDR_TYPE_END) begin
          hdr_type = hdr_word;
          name_hit = (name_len == NAME_BYTES);
          open_name();
        end
      end
      PH_NAME: begin
        if (byte_pos < CNT_W'(NAME_BYTES) && name_hit &&
            b != want_name[8*byte_pos[1:0] +: 8])
          name_hit = 1'b0;
        byte_pos++;
        if (byte_pos >= padded_size(name_len)) open_descriptor();
      end
      default: begin
        if (is_build_id_note() && !id_seen && desc_size == 32'(ID_BYTES) &&
            byte_pos < CNT_W'(ID_BYTES))
          id_copy[int'(byte_pos)] = b;
        byte_pos++;
        if (byte_pos >= padded_size(desc_size)) close_note();
      end
    endcase
  endfunction

  // Works out the results caused by one accepted section byte
  function automatic void predict_section_byte(input logic [7:0] b, input logic fin);
    fail_e why;
    sent_bytes++;
    if (first_fault == FAIL_OK) parse_note_byte(b);
    if (!fin) return;
    if (first_fault != FAIL_OK) why = first_fault;
    else if (sec_phase != PH_HEADER || byte_pos != '0) why = FAIL_TRUNC;
    else if (!id_seen) why = FAIL_NOT_FOUND;
    else why = FAIL_OK;
    if (why == FAIL_OK) begin
      for (int k = 0; k < ID_BYTES; k++)
        pending_results.push_back('{id_byte: id_copy[k], success: 1'b1,
                                    fail_reason: FAIL_OK, run_end: k == ID_BYTES - 1});
    end else begin
      pending_results.push_back('{id_byte: 8'h00, success: 1'b0,
                                  fail_reason: why, run_end: 1'b1});
    end
    clear_section();
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_id_result();
    id_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with none expected", 32'(id_ch.id_byte), 32'h0);
      return;
    end
    want = pending_results.pop_front();
    if (id_ch.id_byte !== want.id_byte)
      report_mismatch("id_byte", 32'(id_ch.id_byte), 32'(want.id_byte));
    if (id_ch.success !== want.success)
      report_mismatch("success", 32'(id_ch.success), 32'(want.success));
    if (id_ch.fail_reason !== want.fail_reason)
      report_mismatch("fail_reason", 32'(id_ch.fail_reason), 32'(want.fail_reason));
    if (id_ch.run_end !== want.run_end)
      report_mismatch("run_end", 32'(id_ch.run_end), 32'(want.run_end));
  endtask

  // Prediction first, then the check, so a same-edge result finds its expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready)
        predict_section_byte(byte_ch.data_byte, byte_ch.final_byte);
      if (id_ch.valid && id_ch.ready) check_id_result();
    end
  end

  // Ends the run if no transaction moves for too long
  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (id_ch.valid && id_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side back-pressure, switching among four patterns in turn
  initial begin
    rx_mode_e mode;
    id_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      mode = rx_mode_e'((rx_cycle / 90) % 4);
      case (mode)
        RX_STEADY:      id_ch.ready <= 1'b1;
        RX_EVERY_THIRD: id_ch.ready <= (rx_cycle % 3) != 0;
        RX_COIN:        id_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (rx_hold != 0) begin
            rx_hold--;
            id_ch.ready <= 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(2, 12);
            id_ch.ready <= 1'b0;
          end else begin
            id_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Sends one section byte, in bursts with random gaps
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= b;
    byte_ch.final_byte <= fin;
    do @(posedge clk_i); while (!byte_ch.ready);
    burst_left--;
  endtask

  task automatic send_section(input int count);
    for (int i = 0; i < count; i++) send_byte(section_bytes[i], i == count - 1);
  endtask

  // Holds the input off until every expected result has arrived
  task automatic await_all_results();
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_match_settings(input logic [31:0] ntype, input logic [31:0] nword);
    await_all_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_NOTE_TYPE;
    cfg_data_i <= ntype;
    @(posedge clk_i);
    cfg_idx_i  <= REG_NAME_WORD;
    cfg_data_i <= nword;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    want_type = ntype;
    want_name = nword;
  endtask

  function automatic void push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) section_bytes.push_back(w[8*i +: 8]);
  endfunction

  // Appends a note with small sizes; first four name bytes from nword when use_name is set
  function automatic void add_note(input logic [31:0] namesz, input logic [31:0] descsz,
                                   input logic [31:0] ntype, input logic [31:0] nword,
                                   input logic use_name);
    int nlen;
    int dlen;
    nlen = int'(padded_size(namesz));
    dlen = int'(padded_size(descsz));
    push_word(namesz);
    push_word(descsz);
    push_word(ntype);
    for (int i = 0; i < nlen; i++)
      section_bytes.push_back((use_name && i < 4) ? nword[8*i +: 8] : 8'($urandom));
    for (int i = 0; i < dlen; i++) section_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_build_id_note();
    add_note(NAME_BYTES, ID_BYTES, want_type, want_name, 1'b1);
  endfunction

  // Near misses and unrelated notes
  function automatic void add_other_note();
    case ($urandom_range(0, 3))
      0: add_note(NAME_BYTES, ID_BYTES, want_type,
                  want_name ^ (32'd1 << $urandom_range(0, 31)), 1'b1);
      1: add_note(NAME_BYTES, ID_BYTES, want_type ^ (32'd1 << $urandom_range(0, 31)),
                  want_name, 1'b1);
      default: add_note($urandom_range(0, 9), $urandom_range(0, 24),
                        $urandom_range(0, 1) ? want_type : $urandom, want_name,
                        1'($urandom_range(0, 1)));
    endcase
  endfunction

  task automatic build_random_section(output int count);
    int pick;
    int bad_size;
    section_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // one build id among other notes
      repeat ($urandom_range(0, 1)) add_other_note();
      add_build_id_note();
      repeat ($urandom_range(0, 1)) add_other_note();
    end else if (pick < 58) begin
      // two build ids
      add_build_id_note();
      repeat ($urandom_range(0, 1)) add_other_note();
      add_build_id_note();
    end else if (pick < 68) begin
      // size fault first; a later good note must not change the reason
      bad_size = $urandom_range(0, 24);
      if (bad_size == ID_BYTES) bad_size++;
      add_note(NAME_BYTES, bad_size, want_type, want_name, 1'b1);
      repeat ($urandom_range(0, 1)) add_build_id_note();
    end else if (pick < 78) begin
      repeat ($urandom_range(1, 3)) add_other_note();
    end else if (pick < 90) begin
      add_build_id_note();
      add_other_note();
      count = $urandom_range(1, section_bytes.size() - 1);
      return;
    end else if ($urandom_range(0, 1)) begin
      // header with any sizes, cut off early
      push_word($urandom);
      push_word($urandom);
      push_word($urandom_range(0, 1) ? want_type : $urandom);
      repeat ($urandom_range(0, 8)) section_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 10)) section_bytes.push_back(8'($urandom));
    end
    count = section_bytes.size();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_build_id_with_reset_settings();
    section_bytes.delete();
    add_build_id_note();
    send_section(section_bytes.size());
  endtask

  task automatic test_single_byte_section();
    section_bytes.delete();
    section_bytes.push_back(8'($urandom));
    send_section(1);
  endtask

  task automatic test_note_without_build_id();
    section_bytes.delete();
    add_note(32'h0, 32'h0, 32'hFFFF_FFFF, want_name, 1'b0);
    send_section(section_bytes.size());
  endtask

  task automatic test_wrong_descriptor_size();
    section_bytes.delete();
    add_note(NAME_BYTES, 32'h0, want_type, want_name, 1'b1);
    send_section(section_bytes.size());
  endtask

  task automatic test_wide_sizes();
    section_bytes.delete();
    push_word(32'hFFFF_FFFF);
    push_word(32'hFFFF_FFFF);
    push_word(want_type);
    repeat (3) section_bytes.push_back(8'($urandom));
    send_section(section_bytes.size());
  endtask

  task automatic test_random_sections(input int unsigned budget);
    int unsigned start;
    int          sections;
    int          count;
    start    = sent_bytes;
    sections = 0;
    while (sent_bytes - start < budget) begin
      build_random_section(count);
      send_section(count);
      sections++;
      if (sections == 2 || $urandom_range(0, 4) == 0) await_all_results();
    end
  endtask

  task automatic test_register_settings();
    logic [31:0] types [4];
    logic [31:0] names [4];
    types = '{32'h0, 32'hFFFF_FFFF, $urandom, RST_NOTE_TYPE};
    names = '{32'h0, 32'hFFFF_FFFF, $urandom, RST_NAME_WORD};
    for (int s = 0; s < 4; s++) begin
      apply_match_settings(types[s], names[s]);
      test_random_sections(10);
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_NOTE_TYPE;
    cfg_data_i         <= '0;
    byte_ch.valid      <= 1'b0;
    byte_ch.data_byte  <= 8'h00;
    byte_ch.final_byte <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_build_id_with_reset_settings();
    test_single_byte_section();
    test_note_without_build_id();
    test_wrong_descriptor_size();
    test_wide_sizes();
    test_random_sections(30);
    test_register_settings();

    await_all_results();
    repeat (ID_BYTES + 8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
